// File: rtl/floating_horizon_line_raster_top_macros.svh
// Assertion macros shared by the horizon rasterizer RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef FLOATING_HORIZON_LINE_RASTER_TOP_MACROS_SVH
`define FLOATING_HORIZON_LINE_RASTER_TOP_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define FHLR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define FHLR_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/fhlr_pkg.sv
// Package of the floating horizon line rasterizer: screen constants, horizon types,
// shade codes and coordinate helpers. Depends on nothing.
`default_nettype none

package fhlr_pkg;

  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 64;

  // Width of one coordinate field on the stream ports.
  localparam int COORD_W = 6;
  localparam int COL_W   = $clog2(SCREEN_WIDTH);
  localparam int ROW_W   = $clog2(SCREEN_HEIGHT);
  localparam int MAG_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  // Bresenham error term, with headroom for the doubled value.
  localparam int ERR_W   = MAG_W + 3;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 2;

  // Bit positions of the input flags inside in_tuser.
  localparam int IN_FIRST_BIT = 0;
  localparam int IN_FRAME_BIT = 1;

  typedef enum logic [1:0] {
    SHADE_BOTH   = 2'd0,
    SHADE_TOP    = 2'd1,
    SHADE_BOTTOM = 2'd2,
    SHADE_HIDDEN = 2'd3
  } shade_t;

  // One top/bottom horizon pair of a column.
  typedef struct packed {
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] bot;
  } hz_pair_t;

  localparam hz_pair_t HZ_RESET = '{top: ROW_W'(SCREEN_HEIGHT - 1), bot: '0};

  // A memory word holds two banks; a per-column select says which one is current.
  typedef struct packed {
    hz_pair_t b1;
    hz_pair_t b0;
  } hz_word_t;

  // Requests from the walker to the horizon store.
  typedef struct packed {
    logic             rd_en;
    logic [COL_W-1:0] rd_col;
    logic             wr_en;
    logic [COL_W-1:0] wr_col;
    hz_pair_t         wr_next;
    logic             clear;
    logic             commit;
  } hz_ctl_t;

  // Current and next-row horizons of the column read last.
  typedef struct packed {
    hz_pair_t cur;
    hz_pair_t nxt;
  } hz_view_t;

  function automatic logic [COL_W-1:0] sat_col(input logic [COORD_W-1:0] v);
    if (v > COORD_W'(SCREEN_WIDTH - 1)) begin
      return COL_W'(SCREEN_WIDTH - 1);
    end
    return v[COL_W-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] sat_row(input logic [COORD_W-1:0] v);
    if (v > COORD_W'(SCREEN_HEIGHT - 1)) begin
      return ROW_W'(SCREEN_HEIGHT - 1);
    end
    return v[ROW_W-1:0];
  endfunction

  function automatic shade_t shade_of(input logic above, input logic below);
    shade_t s;
    case ({below, above})
      2'b11:   s = SHADE_BOTH;
      2'b01:   s = SHADE_TOP;
      2'b10:   s = SHADE_BOTTOM;
      default: s = SHADE_HIDDEN;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/floating_horizon_line_raster_top.sv
// Flow: an accepted vertex is judged in the next cycle; a drawn segment is then
// walked one pixel at a time, each column read in S_RD and written back in S_PIX,
// which waits while the output register is full. A new vertex is accepted only in
// S_IDLE, after the last one is through; the memory read-then-write sets the pace.
// Reset: synchronous, active low; horizons read as their reset values at once,
// with no clearing pass, and the previous vertex is cleared to column 0, row 0.
// Top level of the floating horizon line rasterizer.
// Depends on fhlr_pkg, fhlr_hzn_store and the assertion macros header.
`default_nettype none

module floating_horizon_line_raster_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // Fields from bit 0: vertex_x[5:0], vertex_y[11:6], zero fill [15:12].
  input  wire logic [fhlr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0: row_first[0], frame_start[1].
  input  wire logic [fhlr_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  wire logic                             in_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // Fields from bit 0: pixel_x[5:0], pixel_y[11:6], zero fill [15:12].
  output logic [fhlr_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // Fields from bit 0: shade[1:0].
  output logic [fhlr_pkg::OUT_TUSER_W-1:0]      out_tuser,
  output logic                                  out_tlast
);

  `include "floating_horizon_line_raster_top_macros.svh"

  localparam int CW = fhlr_pkg::COL_W;
  localparam int RW = fhlr_pkg::ROW_W;
  localparam int EW = fhlr_pkg::ERR_W;
  localparam int DW = fhlr_pkg::COORD_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_VIS  = 4'b0010,
    S_RD   = 4'b0100,
    S_PIX  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Vertex being handled and previous vertex.
  logic [CW-1:0] x1_r, x1_nxt;
  logic [RW-1:0] y1_r, y1_nxt;
  logic          first_r, first_nxt;
  logic          row_end_r, row_end_nxt;
  logic [CW-1:0] prev_x_r, prev_x_nxt;
  logic [RW-1:0] prev_y_r, prev_y_nxt;
  logic          prev_vis_r, prev_vis_nxt;

  // Walk state.
  logic [CW-1:0]        x0_r, x0_nxt;
  logic [RW-1:0]        y0_r, y0_nxt;
  logic [CW-1:0]        dx_r, dx_nxt;
  logic [RW-1:0]        ady_r, ady_nxt;
  logic                 sx_r, sx_nxt;
  logic                 sy_r, sy_nxt;
  logic signed [EW-1:0] err_r, err_nxt;

  // Output register.
  logic                                out_valid_r, out_valid_nxt;
  logic [fhlr_pkg::OUT_TDATA_W-1:0]    out_data_r, out_data_nxt;
  logic [fhlr_pkg::OUT_TUSER_W-1:0]    out_user_r, out_user_nxt;
  logic                                out_last_r, out_last_nxt;

  fhlr_pkg::hz_ctl_t  ctl;
  fhlr_pkg::hz_view_t view;

  logic          accept;
  logic [CW-1:0] in_x;
  logic [RW-1:0] in_y;
  logic          vis;
  logic          draw;
  logic [CW-1:0] dx_init;
  logic [RW-1:0] ady_init;
  logic signed [EW-1:0] err_init;
  logic signed [EW:0]   e2;
  logic signed [EW:0]   dx_s;
  logic signed [EW:0]   ady_s;
  logic signed [EW:0]   err_sum;
  logic          step_x;
  logic          step_y;
  logic          pix_end;
  logic          out_free;
  logic          fire;
  logic          above;
  logic          below;
  fhlr_pkg::shade_t shade;
  logic [CW-1:0] dist_x;
  logic [RW-1:0] dist_y;

  fhlr_hzn_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .view  (view)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign in_x       = fhlr_pkg::sat_col(in_tdata[DW-1:0]);
  assign in_y       = fhlr_pkg::sat_row(in_tdata[2*DW-1:DW]);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // Vertex visibility and segment setup from the previous vertex.
  always_comb begin
    vis      = (y1_r < view.cur.top) || (y1_r > view.cur.bot);
    draw     = !first_r && (prev_vis_r || vis);
    dx_init  = (x1_r > prev_x_r) ? (x1_r - prev_x_r) : (prev_x_r - x1_r);
    ady_init = (y1_r > prev_y_r) ? (y1_r - prev_y_r) : (prev_y_r - y1_r);
    err_init = $signed(EW'(dx_init)) - $signed(EW'(ady_init));
  end

  // Bresenham step decision on the doubled error term.
  always_comb begin
    e2      = $signed({err_r, 1'b0});
    dx_s    = $signed((EW + 1)'(dx_r));
    ady_s   = $signed((EW + 1)'(ady_r));
    step_x  = (e2 >= -ady_s);
    step_y  = (e2 <= dx_s);
    err_sum = $signed((EW + 1)'(err_r)) + (step_x ? -ady_s : '0) + (step_y ? dx_s : '0);
    pix_end = (x0_r == x1_r) && (y0_r == y1_r);
    dist_x  = sx_r ? (x1_r - x0_r) : (x0_r - x1_r);
    dist_y  = sy_r ? (y1_r - y0_r) : (y0_r - y1_r);
  end

  // Pixel classification against the horizons of its column.
  always_comb begin
    above = (view.cur.top > y0_r);
    below = (view.cur.bot < y0_r);
    shade = fhlr_pkg::shade_of(above, below);
  end

  assign out_free = !out_valid_r || out_tready;
  assign fire     = (state_r == S_PIX) && out_free;

  // Sequencer: accept, judge the vertex, then read and write back one pixel at a time.
  always_comb begin
    state_nxt     = state_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    first_nxt     = first_r;
    row_end_nxt   = row_end_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    prev_vis_nxt  = prev_vis_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    dx_nxt        = dx_r;
    ady_nxt       = ady_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;

    ctl.rd_en     = 1'b0;
    ctl.rd_col    = x0_r;
    ctl.wr_en     = 1'b0;
    ctl.wr_col    = x0_r;
    ctl.wr_next   = view.nxt;
    ctl.clear     = 1'b0;
    ctl.commit    = 1'b0;

    case (state_r)
      S_IDLE: begin
        ctl.rd_col = in_x;
        if (accept) begin
          ctl.rd_en   = 1'b1;
          ctl.clear   = in_tuser[fhlr_pkg::IN_FRAME_BIT];
          x1_nxt      = in_x;
          y1_nxt      = in_y;
          first_nxt   = in_tuser[fhlr_pkg::IN_FIRST_BIT] || in_tuser[fhlr_pkg::IN_FRAME_BIT];
          row_end_nxt = in_tlast;
          state_nxt   = S_VIS;
        end
      end
      S_VIS: begin
        x0_nxt       = prev_x_r;
        y0_nxt       = prev_y_r;
        dx_nxt       = dx_init;
        ady_nxt      = ady_init;
        sx_nxt       = (prev_x_r < x1_r);
        sy_nxt       = (prev_y_r < y1_r);
        err_nxt      = err_init;
        prev_x_nxt   = x1_r;
        prev_y_nxt   = y1_r;
        prev_vis_nxt = vis;
        if (draw) begin
          state_nxt = S_RD;
        end else begin
          ctl.commit = row_end_r;
          state_nxt  = S_IDLE;
        end
      end
      S_RD: begin
        ctl.rd_en = 1'b1;
        state_nxt = S_PIX;
      end
      S_PIX: begin
        if (fire) begin
          // Write back the running minimum and maximum for the next row.
          ctl.wr_en = 1'b1;
          if (above && (view.nxt.top > y0_r)) begin
            ctl.wr_next.top = y0_r;
          end
          if (below && (view.nxt.bot < y0_r)) begin
            ctl.wr_next.bot = y0_r;
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = fhlr_pkg::OUT_TDATA_W'({DW'(y0_r), DW'(x0_r)});
          out_user_nxt  = fhlr_pkg::OUT_TUSER_W'(shade);
          out_last_nxt  = pix_end;
          if (pix_end) begin
            ctl.commit = row_end_r;
            state_nxt  = S_IDLE;
          end else begin
            if (step_x) begin
              x0_nxt = sx_r ? (x0_r + CW'(1)) : (x0_r - CW'(1));
            end
            if (step_y) begin
              y0_nxt = sy_r ? (y0_r + RW'(1)) : (y0_r - RW'(1));
            end
            err_nxt   = err_sum[EW-1:0];
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_vis_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      prev_vis_r  <= prev_vis_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    first_r    <= first_nxt;
    row_end_r  <= row_end_nxt;
    x0_r       <= x0_nxt;
    y0_r       <= y0_nxt;
    dx_r       <= dx_nxt;
    ady_r      <= ady_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  // Every step of the walk moves toward the end vertex, never away.
  `FHLR_ASSERT(a_walk_converges, (state_r == S_RD) && $past(state_r == S_PIX) |-> (dist_x <= $past(dist_x)) && (dist_y <= $past(dist_y)), "walk moved away from end vertex")
  // A pixel is only classified after its column was read in S_RD; S_PIX may hold while the output stalls.
  `FHLR_ASSERT(a_pix_after_read, (state_r == S_PIX) |-> $past(state_r == S_RD) || $past(state_r == S_PIX), "pixel stage entered without a read")

endmodule

`default_nettype wire

// File: rtl/fhlr_hzn_store.sv
// Horizon store: one synchronous memory with two horizon banks per column,
// plus per-column clear, same and bank-select flags. Depends on fhlr_pkg and the macros header.
`default_nettype none

module fhlr_hzn_store (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fhlr_pkg::hz_ctl_t  ctl,
  output fhlr_pkg::hz_view_t      view
);

  `include "floating_horizon_line_raster_top_macros.svh"

  localparam int DEPTH = fhlr_pkg::SCREEN_WIDTH;

  fhlr_pkg::hz_word_t           mem [DEPTH];
  fhlr_pkg::hz_word_t           rdata_r;
  logic [fhlr_pkg::COL_W-1:0]   rcol_r;

  // cleared: column holds reset values in both banks.
  // same: next-row bank is stale and equals the current bank.
  // sel: bank 1 holds the current horizons.
  logic [DEPTH-1:0] cleared_r, cleared_nxt;
  logic [DEPTH-1:0] same_r,    same_nxt;
  logic [DEPTH-1:0] sel_r,     sel_nxt;

  fhlr_pkg::hz_pair_t bank_cur;
  fhlr_pkg::hz_pair_t bank_nxt;
  fhlr_pkg::hz_word_t wr_word;

  // Resolve the word read last through the column flags.
  always_comb begin
    bank_cur = sel_r[rcol_r] ? rdata_r.b1 : rdata_r.b0;
    bank_nxt = sel_r[rcol_r] ? rdata_r.b0 : rdata_r.b1;
    if (cleared_r[rcol_r]) begin
      view.cur = fhlr_pkg::HZ_RESET;
      view.nxt = fhlr_pkg::HZ_RESET;
    end else begin
      view.cur = bank_cur;
      view.nxt = same_r[rcol_r] ? bank_cur : bank_nxt;
    end
  end

  // A write stores the resolved current pair and the new next-row pair.
  always_comb begin
    if (sel_r[ctl.wr_col]) begin
      wr_word.b1 = view.cur;
      wr_word.b0 = ctl.wr_next;
    end else begin
      wr_word.b0 = view.cur;
      wr_word.b1 = ctl.wr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_col] <= wr_word;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[ctl.rd_col];
      rcol_r  <= ctl.rd_col;
    end
  end

  // Flag update: a clear marks every column reset, a write marks its column live, then a commit makes next current.
  always_comb begin
    cleared_nxt = cleared_r;
    same_nxt    = same_r;
    sel_nxt     = sel_r;
    if (ctl.clear) begin
      cleared_nxt = '1;
      same_nxt    = '1;
    end
    if (ctl.wr_en) begin
      cleared_nxt[ctl.wr_col] = 1'b0;
      same_nxt[ctl.wr_col]    = 1'b0;
    end
    if (ctl.commit) begin
      sel_nxt  = sel_nxt ^ ~same_nxt;
      same_nxt = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cleared_r <= '1;
      same_r    <= '1;
      sel_r     <= '0;
    end else begin
      cleared_r <= cleared_nxt;
      same_r    <= same_nxt;
      sel_r     <= sel_nxt;
    end
  end

  // The write-back column must be the one whose word was read.
  `FHLR_ASSERT(a_wr_col_read, ctl.wr_en |-> ctl.wr_col == rcol_r, "write to a column not read")
  // After a commit every next-row bank is in step with its current bank.
  `FHLR_ASSERT(a_commit_same, ctl.commit |=> (&same_r), "commit left stale next-row bank")

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the floating horizon line rasterizer.
// Drives projected grid vertices into floating_horizon_line_raster_top, predicts every stepped
// pixel and its shade, and compares the pixel stream. Depends on fhlr_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int STUCK_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 20;
  localparam int GAP_PERCENT = 38;
  localparam int MAX_SEGMENT = 64;

  // One expected pixel of a segment walk.
  typedef struct {
    logic [5:0]       col;
    logic [5:0]       row;
    fhlr_pkg::shade_t shade;
    logic             seg_end;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [fhlr_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [fhlr_pkg::IN_TUSER_W-1:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [fhlr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [fhlr_pkg::OUT_TUSER_W-1:0] out_tuser;
  logic out_tlast;

  // Horizon model: current and next-row copies per column, plus the previous vertex.
  logic [5:0] top_cur [fhlr_pkg::SCREEN_WIDTH];
  logic [5:0] bot_cur [fhlr_pkg::SCREEN_WIDTH];
  logic [5:0] top_nxt [fhlr_pkg::SCREEN_WIDTH];
  logic [5:0] bot_nxt [fhlr_pkg::SCREEN_WIDTH];
  int         last_col;
  int         last_row;
  logic       last_vis;

  pixel_t awaited_pixels[$];

  logic gaps_on = 1'b1;
  int unsigned stuck_cycles = 0;
  int error_count = 0;
  int vertex_count = 0;
  int segment_count = 0;
  int silent_count = 0;
  int pixel_count = 0;
  int shade_count [4];

  floating_horizon_line_raster_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // The receiver stalls at random unless gaps are switched off.
  always @(negedge clk) begin
    out_tready <= !gaps_on || ($urandom_range(0, 99) >= GAP_PERCENT);
  end

  // Return every horizon to its frame-start value.
  function automatic void clear_horizons();
    for (int c = 0; c < fhlr_pkg::SCREEN_WIDTH; c++) begin
      top_cur[c] = 6'(fhlr_pkg::SCREEN_HEIGHT - 1);
      bot_cur[c] = '0;
      top_nxt[c] = 6'(fhlr_pkg::SCREEN_HEIGHT - 1);
      bot_nxt[c] = '0;
    end
  endfunction

  // Shade one pixel against the current horizons and widen the next-row copies.
  function automatic fhlr_pkg::shade_t judge_pixel(input int c, input int r);
    logic above;
    logic below;
    above = r < int'(top_cur[c]);
    below = r > int'(bot_cur[c]);
    if (above && r < int'(top_nxt[c])) begin
      top_nxt[c] = 6'(r);
    end
    if (below && r > int'(bot_nxt[c])) begin
      bot_nxt[c] = 6'(r);
    end
    if (above && below) begin
      return fhlr_pkg::SHADE_BOTH;
    end else if (above) begin
      return fhlr_pkg::SHADE_TOP;
    end else if (below) begin
      return fhlr_pkg::SHADE_BOTTOM;
    end
    return fhlr_pkg::SHADE_HIDDEN;
  endfunction

  // Work out the pixels one accepted vertex causes and update the horizon model.
  task automatic trace_vertex(input logic [5:0] vx, input logic [5:0] vy,
                              input logic first_in, input logic row_end, input logic frame);
    int x0, y0, x1, y1, dx, dy, sx, sy, err, e2, n;
    logic first;
    logic vis;
    logic done;
    pixel_t px;
    // A 6-bit field cannot exceed the 64 by 64 screen, so no saturation applies.
    x1 = vx;
    y1 = vy;
    first = first_in;
    n = 0;
    if (frame) begin
      clear_horizons();
      first = 1'b1;
    end
    vis = (y1 < int'(top_cur[x1])) || (y1 > int'(bot_cur[x1]));
    if (!first && (last_vis || vis)) begin
      x0 = last_col;
      y0 = last_row;
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y0 - y1 : y1 - y0;
      sx = (x0 < x1) ? 1 : -1;
      sy = (y0 < y1) ? 1 : -1;
      err = dx + dy;
      done = 1'b0;
      while (!done && n < MAX_SEGMENT) begin
        px.col = 6'(x0);
        px.row = 6'(y0);
        px.seg_end = (x0 == x1) && (y0 == y1);
        px.shade = judge_pixel(x0, y0);
        awaited_pixels.push_back(px);
        n++;
        done = px.seg_end;
        if (!done) begin
          e2 = 2 * err;
          if (e2 >= dy) begin
            err += dy;
            x0 += sx;
          end
          if (e2 <= dx) begin
            err += dx;
            y0 += sy;
          end
        end
      end
    end
    if (n == 0) begin
      silent_count++;
    end else begin
      segment_count++;
    end
    last_col = x1;
    last_row = y1;
    last_vis = vis;
    // The commit comes after this vertex's own segment.
    if (row_end) begin
      for (int c = 0; c < fhlr_pkg::SCREEN_WIDTH; c++) begin
        top_cur[c] = top_nxt[c];
        bot_cur[c] = bot_nxt[c];
      end
    end
  endtask

  task automatic note_error(input string what);
    error_count++;
    if (error_count <= 10) begin
      $display("[%0t] %s", $realtime, what);
    end
  endtask

  // Compare one pixel transaction with the oldest expectation.
  task automatic check_pixel();
    pixel_t exp_px;
    logic [5:0] got_col;
    logic [5:0] got_row;
    got_col = out_tdata[5:0];
    got_row = out_tdata[11:6];
    pixel_count++;
    shade_count[out_tuser]++;
    if (awaited_pixels.size() == 0) begin
      note_error($sformatf("unexpected pixel x=%0d y=%0d shade=%0d last=%0b",
                           got_col, got_row, out_tuser, out_tlast));
    end else begin
      exp_px = awaited_pixels.pop_front();
      if (got_col !== exp_px.col || got_row !== exp_px.row ||
          out_tuser !== exp_px.shade || out_tlast !== exp_px.seg_end) begin
        note_error($sformatf(
          "pixel mismatch: expected x=%0d y=%0d shade=%0d last=%0b, got x=%0d y=%0d shade=%0d last=%0b",
          exp_px.col, exp_px.row, exp_px.shade, exp_px.seg_end,
          got_col, got_row, out_tuser, out_tlast));
      end
    end
  endtask

  // Watch both channels at the rising edge: predict on input, check on output.
  always @(posedge clk) begin
    if (!rst_n) begin
      stuck_cycles = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        vertex_count++;
        trace_vertex(in_tdata[5:0], in_tdata[11:6], in_tuser[fhlr_pkg::IN_FIRST_BIT],
                     in_tlast, in_tuser[fhlr_pkg::IN_FRAME_BIT]);
      end
      if (out_tvalid && out_tready) begin
        check_pixel();
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
  end

  // Stop a hung run.
  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("watchdog: no transaction for %0d cycles, %0d pixels outstanding",
             STUCK_LIMIT, awaited_pixels.size());
    $display("testbench: errors");
    $finish;
  end

  // Offer one vertex; starts and ends at a falling edge.
  task automatic send_vertex(input int vx, input int vy, input logic first,
                             input logic row_end, input logic frame);
    logic [fhlr_pkg::IN_TUSER_W-1:0] user;
    while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    user = '0;
    user[fhlr_pkg::IN_FIRST_BIT] = first;
    user[fhlr_pkg::IN_FRAME_BIT] = frame;
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, 6'(vy), 6'(vx)};
    in_tuser <= user;
    in_tlast <= row_end;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Hold the sender back until every expected pixel has arrived.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (awaited_pixels.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  function automatic int clamp_coord(input int v);
    if (v < 0) begin
      return 0;
    end else if (v > 63) begin
      return 63;
    end
    return v;
  endfunction

  // A surface grid with random content; some vertices are replaced by noise.
  // Drains the pipeline before vertex pause_at when it is not negative.
  task automatic send_grid(input int rows, input int cols, input int noise_pct,
                           input int pause_at);
    int base, x, y, idx;
    logic flip;
    idx = 0;
    base = $urandom_range(8, 55);
    for (int r = 0; r < rows; r++) begin
      base = clamp_coord(base + $urandom_range(0, 12) - 6);
      flip = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < cols; j++) begin
        if (idx == pause_at) begin
          wait_for_drain();
        end
        idx++;
        x = clamp_coord($urandom_range(0, 6) + (j * 57) / (cols - 1) + $urandom_range(0, 4) - 2);
        if (flip) begin
          x = 63 - x;
        end
        if ($urandom_range(0, 5) == 0) begin
          y = $urandom_range(0, 63);
        end else begin
          y = clamp_coord(base + $urandom_range(0, 20) - 10);
        end
        if ($urandom_range(0, 99) < noise_pct) begin
          send_vertex($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1),
                      $urandom_range(0, 1), $urandom_range(0, 3) == 0);
        end else begin
          send_vertex(x, y, j == 0, j == cols - 1, r == 0 && j == 0);
        end
      end
    end
  endtask

  // Screen extremes, empty and single-pixel segments, hidden vertices and commits.
  task automatic test_directed();
    // After reset the previous vertex is the screen origin.
    send_vertex(10, 20, 1'b0, 1'b0, 1'b0);
    send_vertex(0, 0, 1'b1, 1'b0, 1'b1);
    // Full-length edges of the screen, each the longest possible segment.
    send_vertex(63, 0, 1'b0, 1'b0, 1'b0);
    send_vertex(63, 63, 1'b0, 1'b0, 1'b0);
    send_vertex(0, 63, 1'b0, 1'b0, 1'b0);
    // A repeated vertex gives a single end pixel.
    send_vertex(0, 63, 1'b0, 1'b0, 1'b0);
    send_vertex(40, 5, 1'b0, 1'b1, 1'b0);
    // Frame start without the row-first flag still draws nothing.
    send_vertex(0, 30, 1'b0, 1'b0, 1'b1);
    send_vertex(63, 30, 1'b0, 1'b1, 1'b0);
    // Both endpoints on the committed horizon: no segment.
    send_vertex(0, 30, 1'b1, 1'b0, 1'b0);
    send_vertex(20, 30, 1'b0, 1'b0, 1'b0);
    send_vertex(40, 10, 1'b0, 1'b0, 1'b0);
    // Visible start, hidden end.
    send_vertex(50, 30, 1'b0, 1'b0, 1'b0);
    send_vertex(63, 50, 1'b0, 1'b1, 1'b0);
    send_vertex(0, 5, 1'b1, 1'b0, 1'b0);
    send_vertex(63, 60, 1'b0, 1'b0, 1'b0);
    send_vertex(31, 32, 1'b0, 1'b1, 1'b0);
    // Frame start together with a row end.
    send_vertex(5, 5, 1'b0, 1'b1, 1'b1);
    send_vertex(62, 1, 1'b0, 1'b0, 1'b0);
    send_vertex(1, 62, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_random_grids();
    int start_count;
    start_count = vertex_count;
    while (vertex_count - start_count < 150) begin
      send_grid($urandom_range(2, 5), $urandom_range(3, 9), 10, -1);
    end
  endtask

  task automatic test_full_rate();
    gaps_on = 1'b0;
    send_grid(4, 8, 0, -1);
    gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    send_grid(3, 6, 5, 9);
  endtask

  initial begin
    last_col = 0;
    last_row = 0;
    last_vis = 1'b0;
    clear_horizons();
    for (int s = 0; s < 4; s++) begin
      shade_count[s] = 0;
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_grids();
    test_full_rate();
    test_drain_pause();

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_pixels.size() != 0) begin
      note_error($sformatf("%0d expected pixels never arrived", awaited_pixels.size()));
    end

    $display("run: %0d vertices, %0d drew segments, %0d drew nothing, %0d pixels compared",
             vertex_count, segment_count, silent_count, pixel_count);
    $display("shades seen: both %0d, top %0d, bottom %0d, hidden %0d, failures %0d",
             shade_count[fhlr_pkg::SHADE_BOTH], shade_count[fhlr_pkg::SHADE_TOP],
             shade_count[fhlr_pkg::SHADE_BOTTOM], shade_count[fhlr_pkg::SHADE_HIDDEN],
             error_count);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: floating_horizon_line_raster_top.f
+incdir+rtl
rtl/fhlr_pkg.sv
rtl/fhlr_hzn_store.sv
rtl/floating_horizon_line_raster_top.sv
tb/testbench.sv
